/* rtl/cas_pkg.sv */
// Shared types and constants for the CIGAR alignment scorer.
package cas_pkg;

   localparam int CH_W       = 8;
   localparam int LEN_W      = 32;
   localparam int SCORE_OUT_W = 40;
   localparam int COEF_W     = 4;
   localparam int CSR_IDX_W  = 8;

   localparam logic [CH_W-1:0] CH_0 = 8'h30;
   localparam logic [CH_W-1:0] CH_9 = 8'h39;
   localparam logic [CH_W-1:0] CH_M = 8'h4D;
   localparam logic [CH_W-1:0] CH_X = 8'h58;
   localparam logic [CH_W-1:0] CH_I = 8'h49;
   localparam logic [CH_W-1:0] CH_D = 8'h44;
   localparam logic [CH_W-1:0] CH_S = 8'h53;

   localparam logic [3:0] DEC_RADIX = 4'd10;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MATCH_BONUS      = 8'd0,
      REG_MISMATCH_PENALTY = 8'd1,
      REG_GAP_OPEN         = 8'd2,
      REG_GAP_EXTEND       = 8'd3
   } csr_index_type;

   localparam logic [COEF_W-1:0] MATCH_BONUS_RST      = 4'd2;
   localparam logic [COEF_W-1:0] MISMATCH_PENALTY_RST = 4'd2;
   localparam logic [COEF_W-1:0] GAP_OPEN_RST         = 4'd3;
   localparam logic [COEF_W-1:0] GAP_EXTEND_RST       = 4'd1;

endpackage

/* rtl/cas_req_if.sv */
// Input channel: one CIGAR character per transfer.
interface cas_req_if;
   logic                     valid;
   logic                     ready;
   logic [cas_pkg::CH_W-1:0]  ch;
   logic                     last;
   logic [cas_pkg::LEN_W-1:0] query_length;

   modport source (output valid, ch, last, query_length, input ready);
   modport sink   (input valid, ch, last, query_length, output ready);
endinterface

/* rtl/cas_rsp_if.sv */
// Result channel: score and lengths of one record.
interface cas_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [cas_pkg::SCORE_OUT_W-1:0] score;
   logic [cas_pkg::LEN_W-1:0]         expected_length;
   logic [cas_pkg::LEN_W-1:0]         computed_length;

   modport source (output valid, score, expected_length, computed_length, input ready);
   modport sink   (input valid, score, expected_length, computed_length, output ready);
endinterface

/* rtl/cigar_alignment_scorer_unit.sv */
// Streaming CIGAR scorer: one character per cycle, sustained; an item is taken in every cycle
// unless a finished record result is held on rsp and the item in flight is a last character.
// The first stage builds the decimal run and forms the run's score change with one small
// multiply (coefficient times run); the second stage adds it into the saturating score and
// length sums. A record's result is registered on rsp once its last character leaves the first
// stage, and only when the summed query length equals the one given with that character.
module cigar_alignment_scorer_unit #(
   parameter int RUN_BITS   = 24,
   parameter int SCORE_BITS = 40
) (
   input  logic                              clock,
   input  logic                              reset,
   cas_req_if.sink                           req_bus,
   cas_rsp_if.source                         rsp_bus,
   input  logic                              csr_we,
   input  logic [cas_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cas_pkg::COEF_W-1:0]        csr_wdata
);
   import cas_pkg::*;

   localparam int PROD_W    = RUN_BITS + 4;
   localparam int DELTA_W   = RUN_BITS + 6;
   localparam int SUM_W     = ((SCORE_BITS > DELTA_W) ? SCORE_BITS : DELTA_W) + 1;
   localparam int LEN_SUM_W = ((RUN_BITS > LEN_W) ? RUN_BITS : LEN_W) + 1;
   localparam int EXT_W     = (SCORE_BITS > SCORE_OUT_W) ? SCORE_BITS : SCORE_OUT_W;

   typedef struct packed {
      logic                    last;
      logic [LEN_W-1:0]        qlen;
      logic [DELTA_W-1:0]      delta;
      logic [RUN_BITS-1:0]     len_add;
   } stage_type;

   // configuration
   logic [COEF_W-1:0] match_bonus_ff, mismatch_penalty_ff, gap_open_ff, gap_extend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_bonus_ff      <= MATCH_BONUS_RST;
         mismatch_penalty_ff <= MISMATCH_PENALTY_RST;
         gap_open_ff         <= GAP_OPEN_RST;
         gap_extend_ff       <= GAP_EXTEND_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MATCH_BONUS:      match_bonus_ff      <= csr_wdata;
            REG_MISMATCH_PENALTY: mismatch_penalty_ff <= csr_wdata;
            REG_GAP_OPEN:         gap_open_ff         <= csr_wdata;
            REG_GAP_EXTEND:       gap_extend_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // state
   logic [RUN_BITS-1:0]          run_length_ff, run_length_in;
   logic                         have_digits_ff, have_digits_in;
   logic signed [SCORE_BITS-1:0] score_sum_ff, score_sum_in;
   logic [LEN_W-1:0]             length_sum_ff, length_sum_in;
   logic                         s1_valid_ff;
   stage_type                    s1_ff, s1_in;
   logic                         rsp_valid_ff;
   logic signed [SCORE_OUT_W-1:0] rsp_score_ff;
   logic [LEN_W-1:0]             rsp_expected_ff, rsp_computed_ff;

   logic accept, out_free, proceed, len_match;

   // stage 1: run builder and score change
   logic                    is_digit, is_op, is_len_op;
   logic [3:0]              digit;
   logic [PROD_W-1:0]       run_wide, prod;
   logic [COEF_W-1:0]       coef;
   logic signed [DELTA_W-1:0] delta;

   assign is_digit = (req_bus.ch >= CH_0) && (req_bus.ch <= CH_9);
   assign digit    = 4'(req_bus.ch - CH_0);
   assign run_wide = PROD_W'(run_length_ff) * PROD_W'(DEC_RADIX) + PROD_W'(digit);
   assign prod     = PROD_W'(coef) * PROD_W'(run_length_ff);

   always_comb begin
      is_op     = 1'b0;
      is_len_op = 1'b0;
      coef      = '0;
      delta     = '0;
      case (req_bus.ch) inside
         CH_M: begin
            is_op = 1'b1; is_len_op = 1'b1; coef = match_bonus_ff;
            delta = $signed({2'b00, prod});
         end
         CH_X: begin
            is_op = 1'b1; is_len_op = 1'b1; coef = mismatch_penalty_ff;
            delta = -$signed({2'b00, prod});
         end
         CH_I, CH_D: begin
            is_op = 1'b1; is_len_op = (req_bus.ch == CH_I); coef = gap_extend_ff;
            // -(open + (run - 1) * extend)
            delta = $signed(DELTA_W'(gap_extend_ff)) - $signed(DELTA_W'(gap_open_ff))
                    - $signed({2'b00, prod});
         end
         CH_S: begin
            is_op = 1'b1; is_len_op = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      run_length_in  = '0;
      have_digits_in = 1'b0;
      if (is_digit && !req_bus.last) begin
         have_digits_in = 1'b1;
         run_length_in  = (run_wide > PROD_W'({RUN_BITS{1'b1}})) ? {RUN_BITS{1'b1}}
                                                                : run_wide[RUN_BITS-1:0];
      end
      s1_in.last    = req_bus.last;
      s1_in.qlen    = req_bus.query_length;
      s1_in.delta   = (is_op && have_digits_ff) ? delta : '0;
      s1_in.len_add = (is_len_op && have_digits_ff) ? run_length_ff : '0;
   end

   // stage 2: saturating accumulate
   logic signed [SUM_W-1:0]      score_wide, score_hi, score_lo;
   logic signed [SCORE_BITS-1:0] score_next;
   logic [LEN_SUM_W-1:0]         len_wide;
   logic [LEN_W-1:0]             length_next;
   logic signed [EXT_W-1:0]      score_ext;

   assign score_hi   = SUM_W'($signed({1'b0, {(SCORE_BITS-1){1'b1}}}));
   assign score_lo   = SUM_W'($signed({1'b1, {(SCORE_BITS-1){1'b0}}}));
   assign score_wide = SUM_W'(score_sum_ff) + SUM_W'($signed(s1_ff.delta));
   assign score_next = (score_wide > score_hi) ? score_hi[SCORE_BITS-1:0] :
                       (score_wide < score_lo) ? score_lo[SCORE_BITS-1:0] :
                                                 score_wide[SCORE_BITS-1:0];
   assign len_wide    = LEN_SUM_W'(length_sum_ff) + LEN_SUM_W'(s1_ff.len_add);
   assign length_next = (len_wide > LEN_SUM_W'({LEN_W{1'b1}})) ? {LEN_W{1'b1}}
                                                              : len_wide[LEN_W-1:0];
   assign score_ext   = EXT_W'(score_next);
   assign len_match   = (length_next == s1_ff.qlen);

   assign out_free        = !rsp_valid_ff || rsp_bus.ready;
   assign proceed         = s1_valid_ff && (!s1_ff.last || out_free);
   assign req_bus.ready   = !s1_valid_ff || proceed;
   assign accept          = req_bus.valid && req_bus.ready;

   always_comb begin
      score_sum_in  = score_sum_ff;
      length_sum_in = length_sum_ff;
      if (proceed) begin
         score_sum_in  = s1_ff.last ? '0 : score_next;
         length_sum_in = s1_ff.last ? '0 : length_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_length_ff  <= '0;
         have_digits_ff <= 1'b0;
         score_sum_ff   <= '0;
         length_sum_ff  <= '0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         score_sum_ff  <= score_sum_in;
         length_sum_ff <= length_sum_in;
         if (accept) begin
            run_length_ff  <= run_length_in;
            have_digits_ff <= have_digits_in;
            s1_valid_ff    <= 1'b1;
         end else if (proceed) begin
            s1_valid_ff <= 1'b0;
         end
         if (proceed && s1_ff.last && len_match) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (proceed && s1_ff.last && len_match) begin
         rsp_score_ff    <= score_ext[SCORE_OUT_W-1:0];
         rsp_expected_ff <= s1_ff.qlen;
         rsp_computed_ff <= length_next;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.score           = rsp_score_ff;
   assign rsp_bus.expected_length = rsp_expected_ff;
   assign rsp_bus.computed_length = rsp_computed_ff;

`ifndef SYNTHESIS
   // a new result only follows a last character that reached the accumulator
   a_rsp_after_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(proceed && s1_ff.last))
      else $error("result raised without a closing last character");

   // sums are cleared once a record closes
   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      (proceed && s1_ff.last) |=> (score_sum_ff == '0 && length_sum_ff == '0))
      else $error("record sums not cleared after last character");

   // matching length at close yields a result
   a_emit_on_match: assert property (@(posedge clock) disable iff (reset)
      (proceed && s1_ff.last && len_match) |=> rsp_bus.valid)
      else $error("matching record produced no result");
`endif

endmodule

/* dv/cigar_alignment_scorer_unit_test.sv */
// Testbench for the CIGAR alignment scorer: directed, saturation, random and back-pressure tests.
`timescale 1ns / 100ps

module cigar_alignment_scorer_unit_test;
   import cas_pkg::*;

   localparam int RUN_BITS     = 24;
   localparam int SCORE_BITS   = 40;
   localparam longint RUN_MAX  = (64'sd1 <<< RUN_BITS) - 1;
   localparam longint SCORE_HI = (64'sd1 <<< (SCORE_BITS - 1)) - 1;
   localparam longint SCORE_LO = -SCORE_HI - 1;
   localparam longint LEN_MAX  = 64'sd4294967295;
   localparam int DRAIN_CYCLES = 8;
   localparam int STALL_LIMIT  = 4000;
   localparam int PHASE_ITEMS  = 150;

   typedef struct packed {
      logic [SCORE_OUT_W-1:0] score;
      logic [LEN_W-1:0]       expected_length;
      logic [LEN_W-1:0]       computed_length;
   } record_score_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COEF_W-1:0]    csr_wdata;

   cas_req_if req_bus ();
   cas_rsp_if rsp_bus ();

   cigar_alignment_scorer_unit #(
      .RUN_BITS   (RUN_BITS),
      .SCORE_BITS (SCORE_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // scoring coefficients and record state as the block should hold them
   longint coef_match, coef_mismatch, coef_open, coef_extend;
   longint run_acc, score_acc, len_acc;
   bit     run_seen;

   record_score_type pending_scores[$];
   logic [CH_W-1:0] rec_buf[$];
   logic [CH_W-1:0] op_letters[5] = '{CH_M, CH_X, CH_I, CH_D, CH_S};

   int fail_count  = 0;
   int items_sent  = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_left   = 0;
   int stall_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic bit is_op(input logic [CH_W-1:0] c);
      return c == CH_M || c == CH_X || c == CH_I || c == CH_D || c == CH_S;
   endfunction

   function automatic void add_score(input longint delta);
      if (delta > 0 && score_acc > SCORE_HI - delta) score_acc = SCORE_HI;
      else if (delta < 0 && score_acc < SCORE_LO - delta) score_acc = SCORE_LO;
      else score_acc += delta;
   endfunction

   // summed length after c, without touching the state
   function automatic longint length_after(input logic [CH_W-1:0] c);
      longint sum;
      sum = len_acc;
      if (is_op(c) && c != CH_D && run_seen) begin
         sum += run_acc;
         if (sum > LEN_MAX) sum = LEN_MAX;
      end
      return sum;
   endfunction

   function automatic void score_char(input logic [CH_W-1:0] c, input logic is_last,
                                      input logic [LEN_W-1:0] qlen);
      record_score_type res;
      if (c >= CH_0 && c <= CH_9) begin
         run_acc = run_acc * 10 + longint'(c - CH_0);
         if (run_acc > RUN_MAX) run_acc = RUN_MAX;
         run_seen = 1'b1;
      end else begin
         if (is_op(c) && run_seen) begin
            len_acc = length_after(c);
            case (c) inside
               CH_M: add_score(coef_match * run_acc);
               CH_X: add_score(-(coef_mismatch * run_acc));
               CH_I, CH_D: add_score(-(coef_open + (run_acc - 1) * coef_extend));
               default: ;
            endcase
         end
         run_acc  = 0;
         run_seen = 1'b0;
      end
      if (is_last) begin
         if (len_acc == longint'(qlen)) begin
            res.score           = score_acc[SCORE_OUT_W-1:0];
            res.expected_length = qlen;
            res.computed_length = len_acc[LEN_W-1:0];
            pending_scores.push_back(res);
         end
         run_acc   = 0;
         run_seen  = 1'b0;
         score_acc = 0;
         len_acc   = 0;
      end
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_MATCH_BONUS:      coef_match    = val;
         REG_MISMATCH_PENALTY: coef_mismatch = val;
         REG_GAP_OPEN:         coef_open     = val;
         REG_GAP_EXTEND:       coef_extend   = val;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_coefs(input logic [COEF_W-1:0] m, x, o, e);
      write_csr(REG_MATCH_BONUS, m);
      write_csr(REG_MISMATCH_PENALTY, x);
      write_csr(REG_GAP_OPEN, o);
      write_csr(REG_GAP_EXTEND, e);
      // index past the last register must be ignored
      write_csr(CSR_IDX_W'($urandom_range(4, 255)), COEF_W'($urandom));
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_scores.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // entered and left at a falling edge; valid stays high on return
   task automatic send_char(input logic [CH_W-1:0] c, input logic is_last,
                            input logic [LEN_W-1:0] qlen);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.ch           <= c;
      req_bus.last         <= is_last;
      req_bus.query_length <= qlen;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      score_char(c, is_last, qlen);
      items_sent++;
      @(negedge clock);
   endtask

   // sends rec_buf as one record; mode 0: matching length, 1: random, 2: off by one
   task automatic send_record(input int mode);
      logic [LEN_W-1:0] qlen;
      for (int k = 0; k < rec_buf.size(); k++) begin
         if (k == rec_buf.size() - 1) begin
            qlen = LEN_W'(length_after(rec_buf[k]));
            if (mode == 1) qlen = $urandom;
            else if (mode == 2) qlen = qlen + 1;
            send_char(rec_buf[k], 1'b1, qlen);
         end else begin
            send_char(rec_buf[k], 1'b0, $urandom);
         end
      end
      rec_buf.delete();
   endtask

   function automatic void push_run(input longint n, input logic [CH_W-1:0] op);
      string digits;
      digits = $sformatf("%0d", n);
      for (int k = 0; k < digits.len(); k++) rec_buf.push_back(digits[k]);
      rec_buf.push_back(op);
   endfunction

   function automatic void build_random_record();
      int sel;
      longint n;
      logic [CH_W-1:0] op;
      for (int k = $urandom_range(1, 6); k > 0; k--) begin
         sel = $urandom_range(99);
         op  = op_letters[$urandom_range(4)];
         if (sel < 4) begin
            rec_buf.push_back(CH_W'($urandom));
         end else if (sel < 8) begin
            rec_buf.push_back(op);
         end else begin
            sel = $urandom_range(99);
            if (sel < 70) n = $urandom_range(30);
            else if (sel < 90) n = $urandom_range(9999);
            else if (sel < 97) n = $urandom_range(99999999);
            else n = 64'd9999999999;
            if ($urandom_range(19) == 0) rec_buf.push_back(CH_0);
            // lower case letter is not an operation
            if ($urandom_range(29) == 0) op = op | 8'h20;
            push_run(n, op);
         end
      end
      if ($urandom_range(19) == 0) rec_buf.push_back(CH_0 + CH_W'($urandom_range(9)));
   endfunction

   task automatic test_directed();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      push_run(5, CH_M);
      push_run(3, CH_X);
      push_run(2, CH_I);
      push_run(4, CH_D);
      push_run(7, CH_S);
      send_record(0);
      // zero runs on gaps, stray byte, letter without digits, ch of all zeros
      push_run(0, CH_I);
      push_run(0, CH_D);
      rec_buf.push_back(8'hFF);
      rec_buf.push_back(CH_M);
      rec_buf.push_back(8'h00);
      send_record(0);
      // digits left open at the end of the record
      push_run(3, CH_S);
      rec_buf.push_back(CH_0 + CH_W'(4));
      send_record(0);
      // length mismatch: nothing comes back
      push_run(2, CH_M);
      send_record(2);
      wait_idle();
   endtask

   task automatic test_saturation();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      set_coefs(4'd15, 4'd15, 4'd15, 4'd15);
      // runs near or past their width limit on every operation
      push_run(64'd123456789012, CH_M);
      push_run(64'd99999999, CH_X);
      push_run(64'd16777216, CH_I);
      push_run(64'd9999999999, CH_D);
      push_run(64'd16777215, CH_S);
      push_run(64'd16777214, CH_M);
      send_record(0);
      // large negative score from clipped runs
      for (int k = 0; k < 4; k++) push_run(99999999, (k % 2) ? CH_D : CH_X);
      push_run(0, CH_D);
      send_record(0);
      wait_idle();
   endtask

   task automatic test_random();
      int stop_at;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase / 2)
            0: begin req_idle_pct = 32; rsp_idle_pct = 50; end
            1: begin req_idle_pct = 50; rsp_idle_pct = 32; end
            default: begin req_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         case (phase)
            0: set_coefs(MATCH_BONUS_RST, MISMATCH_PENALTY_RST, GAP_OPEN_RST, GAP_EXTEND_RST);
            1: set_coefs(4'd0, 4'd0, 4'd0, 4'd0);
            2: set_coefs(4'd15, 4'd15, 4'd15, 4'd15);
            default: set_coefs(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
                               COEF_W'($urandom));
         endcase
         stop_at = items_sent + PHASE_ITEMS;
         while (items_sent < stop_at) begin
            build_random_record();
            send_record(($urandom_range(99) < 85) ? 0 : $urandom_range(1, 2));
         end
         wait_idle();
      end
   endtask

   task automatic test_backpressure();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_left = 300;
      for (int k = 0; k < 60; k++) begin
         push_run($urandom_range(9), op_letters[$urandom_range(4)]);
         send_record(0);
      end
      wait_idle();
   endtask

   // receiver: random stalls plus an optional long hold-off
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      record_score_type exp_res;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_scores.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result: score %h expected_length %h computed_length %h",
                     $time, rsp_bus.score, rsp_bus.expected_length, rsp_bus.computed_length);
         end else begin
            exp_res = pending_scores.pop_front();
            if (rsp_bus.score !== exp_res.score) begin
               fail_count++;
               $display("%0t: score: expected %h actual %h", $time, exp_res.score,
                        rsp_bus.score);
            end
            if (rsp_bus.expected_length !== exp_res.expected_length) begin
               fail_count++;
               $display("%0t: expected_length: expected %h actual %h", $time,
                        exp_res.expected_length, rsp_bus.expected_length);
            end
            if (rsp_bus.computed_length !== exp_res.computed_length) begin
               fail_count++;
               $display("%0t: computed_length: expected %h actual %h", $time,
                        exp_res.computed_length, rsp_bus.computed_length);
            end
         end
      end
   end

   // watchdog: cycles without any transfer
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("cigar_alignment_scorer_unit_test failed");
         $finish;
      end
   end

   initial begin
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      req_bus.valid        = 1'b0;
      req_bus.ch           = '0;
      req_bus.last         = 1'b0;
      req_bus.query_length = '0;
      coef_match    = MATCH_BONUS_RST;
      coef_mismatch = MISMATCH_PENALTY_RST;
      coef_open     = GAP_OPEN_RST;
      coef_extend   = GAP_EXTEND_RST;
      run_acc   = 0;
      run_seen  = 1'b0;
      score_acc = 0;
      len_acc   = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_saturation();
      test_random();
      test_backpressure();

      if (fail_count == 0) begin
         $display("cigar_alignment_scorer_unit_test passed");
      end else begin
         $display("cigar_alignment_scorer_unit_test failed");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/cas_pkg.sv
rtl/cas_req_if.sv
rtl/cas_rsp_if.sv
rtl/cigar_alignment_scorer_unit.sv
dv/cigar_alignment_scorer_unit_test.sv
